### hdl/pbfe_pkg.sv
// Shared types, command codes and varint helpers for the protobuf field encoder.
package pbfe_pkg;

  localparam int unsigned MaxBytes    = 15;
  localparam int unsigned VarintBytes = 10;
  localparam int unsigned KeyBytes    = 5;

  typedef enum logic [2:0] {
    CMD_VARINT  = 3'd0,
    CMD_ZIGZAG  = 3'd1,
    CMD_FIXED32 = 3'd2,
    CMD_FIXED64 = 3'd3,
    CMD_LENGTH  = 3'd4,
    CMD_RAW     = 3'd5
  } cmd_e;

  localparam logic [2:0] WireVarint  = 3'd0;
  localparam logic [2:0] WireFixed64 = 3'd1;
  localparam logic [2:0] WireLength  = 3'd2;
  localparam logic [2:0] WireFixed32 = 3'd5;

  typedef logic [VarintBytes-1:0][7:0] varint_t;

  // Encoded bytes of one request, first byte in element 0.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               count;
  } frame_t;

  // All ten 7-bit groups with their continuation bits.
  function automatic varint_t varint_bytes(input logic [63:0] v);
    varint_t     b;
    logic [63:0] rest;
    for (int g = 0; g < VarintBytes; g++) begin
      rest = v >> (7 * g);
      b[g] = {((rest >> 7) != 64'd0), rest[6:0]};
    end
    return b;
  endfunction

  // Number of bytes the varint really takes, from 1 to 10.
  function automatic logic [3:0] varint_len(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int g = 1; g < VarintBytes; g++) begin
      if ((v >> (7 * g)) != 64'd0) n = 4'(g + 1);
    end
    return n;
  endfunction

endpackage

### hdl/pbfe_encoder.sv
// Combinational encoder: turns one registered request into a frame of bytes.
module pbfe_encoder import pbfe_pkg::*; (
  input  logic [2:0]  command_i,
  input  logic [28:0] field_number_i,
  input  logic [63:0] value_i,
  output frame_t      frame_o
);

  logic [2:0]                  wire_type;
  logic [63:0]                 key_word;
  varint_t                     key_vb;
  logic [3:0]                  key_len4;
  logic [2:0]                  key_len;
  logic [63:0]                 var_word;
  varint_t                     val_bytes;
  logic [3:0]                  val_len;
  logic [MaxBytes-1:0][7:0]    val_ext;
  logic [MaxBytes-1:0][7:0]    key_ext;
  logic [MaxBytes-1:0][7:0]    shifted;

  always_comb begin
    wire_type = WireVarint;
    var_word  = value_i;
    case (cmd_e'(command_i))
      CMD_ZIGZAG:  var_word  = {value_i[62:0], 1'b0} ^ {64{value_i[63]}};
      CMD_FIXED32: wire_type = WireFixed32;
      CMD_FIXED64: wire_type = WireFixed64;
      CMD_LENGTH:  wire_type = WireLength;
      default:     wire_type = WireVarint;
    endcase
  end

  assign key_word = {32'd0, field_number_i, wire_type};
  assign key_vb   = varint_bytes(key_word);
  assign key_len4 = varint_len(key_word);
  assign key_len  = key_len4[2:0];

  always_comb begin
    key_ext = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (3'(i) < key_len) key_ext[i] = key_vb[i];
    end
  end

  always_comb begin
    val_bytes = varint_bytes(var_word);
    val_len   = varint_len(var_word);
    case (cmd_e'(command_i))
      CMD_FIXED32: begin
        val_bytes = {48'd0, value_i[31:0]};
        val_len   = 4'd4;
      end
      CMD_FIXED64: begin
        val_bytes = {16'd0, value_i};
        val_len   = 4'd8;
      end
      default: ;
    endcase
  end

  // The value bytes land right behind the key.
  assign val_ext = {40'd0, val_bytes};
  assign shifted = val_ext << {key_len, 3'b000};

  always_comb begin
    frame_o = '0;
    case (cmd_e'(command_i))
      CMD_VARINT, CMD_ZIGZAG, CMD_FIXED32, CMD_FIXED64, CMD_LENGTH: begin
        frame_o.bytes = shifted | key_ext;
        frame_o.count = key_len4 + val_len;
      end
      CMD_RAW: begin
        frame_o.bytes[0] = value_i[7:0];
        frame_o.count    = 4'd1;
      end
      default: frame_o = '0;
    endcase
  end

endmodule

### hdl/pbfe_serializer.sv
// Result register: holds one encoded frame and sends it out a byte per cycle while the receiver is ready.
module pbfe_serializer import pbfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  frame_t     frame_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [3:0]               cnt_q, cnt_d;
  logic                     take;

  assign take        = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 4'd0);
  assign out_byte_o  = buf_q[0];
  assign last_o      = (cnt_q == 4'd1);
  // A new frame may enter when the register is empty or its last byte leaves now.
  assign free_o      = (cnt_q == 4'd0) || (last_o && out_ready_i);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = frame_i.bytes;
      cnt_d = frame_i.count;
    end else if (take) begin
      buf_d = {8'd0, buf_q[MaxBytes-1:1]};
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

### hdl/protobuf_field_encoder_top.sv
// Top level of the protobuf wire-format field encoder.
//
// Input channel (in_valid_i / in_ready_o) takes one field request: a command,
// a field number and a 64-bit value. Output channel (out_valid_o / out_ready_i)
// returns the encoded bytes one per transfer, with last_o on the final byte
// of each request. Unused commands produce no bytes at all.
//
// A request is captured in an input register, encoded combinationally and moved
// into the result register once that is free; its first byte is then offered
// from the result register.
// A used command yields 1 to 15 bytes, which leave the result register one per
// transfer; with the receiver always ready, a stream of used requests runs at
// one byte per cycle with no gaps. An unused command passes through the input
// register and loads an empty frame into the result register.
//
// When the receiver stalls, the current byte holds and one further request
// waits in the input register; in_ready_o drops only when both are full.
// Reset empties both registers; no bytes are pending afterwards.
module protobuf_field_encoder_top import pbfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [28:0]        field_number_i,
  input  logic signed [63:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);

  logic        in_valid_q, in_valid_d;
  logic [2:0]  command_q;
  logic [28:0] field_number_q;
  logic [63:0] value_q;
  logic        ser_free;
  logic        load;
  frame_t      frame;

  assign load       = in_valid_q && ser_free;
  assign in_ready_o = !in_valid_q || ser_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      command_q      <= command_i;
      field_number_q <= field_number_i;
      value_q        <= value_i;
    end
  end

  pbfe_encoder u_encoder (
    .command_i      (command_q),
    .field_number_i (field_number_q),
    .value_i        (value_q),
    .frame_o        (frame)
  );

  pbfe_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .frame_i     (frame),
    .free_o      (ser_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
